>>> hw/rtl/dcmw_pkg.sv
package dcmw_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_COMP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_PCT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TELE_DIV   = 3'd4;

    localparam logic [7:0] RIGHT_COMP_RST = 8'd100;
    localparam logic [7:0] TIMEOUT_RST    = 8'd40;
    localparam logic [9:0] MIN_DUTY_RST   = 10'd300;
    localparam logic [6:0] TURN_PCT_RST   = 7'd80;
    localparam logic [7:0] TELE_DIV_RST   = 8'd5;

    // ASCII direction codes
    localparam logic [7:0] DIR_CHAR_F = 8'h46;
    localparam logic [7:0] DIR_CHAR_B = 8'h42;
    localparam logic [7:0] DIR_CHAR_L = 8'h4C;
    localparam logic [7:0] DIR_CHAR_R = 8'h52;

    localparam logic [6:0]  PCT_FULL  = 7'd100;
    localparam logic [9:0]  CMD_MAX   = 10'd1023;
    localparam logic [10:0] RIGHT_MAX = 11'd2047;
    localparam logic [8:0]  IDLE_MAX  = 9'd511;

    // x/100 ~= (x*5242) >> 19, low by at most one for x < 2^18
    localparam logic [12:0] RECIP_100   = 13'd5242;
    localparam int          RECIP_SHIFT = 19;

    typedef struct packed {
        logic accept;
        logic tick;
        logic mul;
        logic est;
        logic fix;
    } dcmw_cmd_t;

    typedef struct packed {
        logic out_free;
    } dcmw_stat_t;

endpackage

>>> hw/rtl/dcmw_ctrl.sv
module dcmw_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  func,
    output logic                  in_stall,
    input  dcmw_pkg::dcmw_stat_t  stat,
    output dcmw_pkg::dcmw_cmd_t   cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_EST,
        S_FIX
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   tick_reg;
    logic   tick_next;
    logic   accept;
    logic   fix_go;

    assign accept = (state_reg == S_IDLE) && in_valid;
    // a tick waits in S_FIX until the output slot is free
    assign fix_go = (state_reg == S_FIX) && (!tick_reg || stat.out_free);

    always_comb
    begin
        state_next = state_reg;
        tick_next  = tick_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MUL;
                    tick_next  = func;
                end
            end
            S_MUL:
            begin
                state_next = S_EST;
            end
            S_EST:
            begin
                state_next = S_FIX;
            end
            S_FIX:
            begin
                if (fix_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tick_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign cmd.accept = accept;
    assign cmd.tick   = accept ? func : tick_reg;
    assign cmd.mul    = (state_reg == S_MUL);
    assign cmd.est    = (state_reg == S_EST);
    assign cmd.fix    = fix_go;

endmodule

>>> hw/rtl/dcmw_dp.sv
module dcmw_dp
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [dcmw_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dcmw_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic [7:0]                             direction,
    input  logic signed [7:0]                      speed,
    input  dcmw_pkg::dcmw_cmd_t                    cmd,
    output dcmw_pkg::dcmw_stat_t                   stat,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [10:0]                     left_drive,
    output logic signed [11:0]                     right_drive,
    output logic                                   telemetry_pulse
);

    typedef enum logic [2:0] {
        DIR_STOP,
        DIR_FWD,
        DIR_BACK,
        DIR_LEFT,
        DIR_RIGHT
    } dir_t;

    // configuration
    logic [7:0] right_comp_reg;
    logic [7:0] timeout_reg;
    logic [9:0] min_duty_reg;
    logic [6:0] turn_pct_reg;
    logic [7:0] tele_div_reg;

    // state
    logic signed [10:0] left_cmd_reg;
    logic signed [10:0] right_cmd_reg;
    logic [8:0]         idle_reg;
    logic [7:0]         tele_reg;

    // working registers
    dir_t        dir_reg;
    logic [9:0]  mag_reg;
    logic        rneg_reg;
    logic        pulse_reg;
    logic [17:0] prod_reg;
    logic [11:0] q_reg;

    // output slot
    logic               out_valid_reg;
    logic signed [10:0] left_out_reg;
    logic signed [11:0] right_out_reg;
    logic               pulse_out_reg;

    logic [6:0]  spd;
    logic [9:0]  scaled;
    logic [9:0]  pwm;
    dir_t        dir_next;
    logic [8:0]  idle_next;
    logic        timeout;
    logic [10:0] neg_right;
    logic [10:0] abs_right;
    logic [8:0]  tele_inc;
    logic        pulse_next;
    logic [7:0]  tele_next;
    logic [7:0]  factor;
    logic [17:0] prod_next;
    logic [30:0] est_full;
    logic [17:0] q_times;
    logic [17:0] rem;
    logic [11:0] q_fix;
    logic [9:0]  turn_mag;
    logic [10:0] cmag;
    logic [11:0] cmag_ext;
    logic signed [10:0] pwm_pos;
    logic signed [10:0] turn_pos;
    logic signed [10:0] left_next;
    logic signed [10:0] right_next;
    logic        out_free;

    // speed clamp and 0..100 -> 0..999 as 10*s - 1 for s > 0
    always_comb
    begin
        if (speed[7])
        begin
            spd = 7'd0;
        end
        else if (speed[6:0] > dcmw_pkg::PCT_FULL)
        begin
            spd = dcmw_pkg::PCT_FULL;
        end
        else
        begin
            spd = speed[6:0];
        end
    end

    assign scaled = ({3'b000, spd} << 3) + ({3'b000, spd} << 1) - {9'd0, |spd};
    assign pwm    = (|scaled && (scaled < min_duty_reg)) ? min_duty_reg : scaled;

    always_comb
    begin
        unique case (direction)
            dcmw_pkg::DIR_CHAR_F: dir_next = DIR_FWD;
            dcmw_pkg::DIR_CHAR_B: dir_next = DIR_BACK;
            dcmw_pkg::DIR_CHAR_L: dir_next = DIR_LEFT;
            dcmw_pkg::DIR_CHAR_R: dir_next = DIR_RIGHT;
            default:              dir_next = DIR_STOP;
        endcase
    end

    // watchdog, saturating
    assign idle_next = (idle_reg == dcmw_pkg::IDLE_MAX) ? idle_reg : idle_reg + 9'd1;
    assign timeout   = idle_next > {1'b0, timeout_reg};
    assign neg_right = -right_cmd_reg;
    assign abs_right = right_cmd_reg[10] ? neg_right : right_cmd_reg;

    assign tele_inc   = {1'b0, tele_reg} + 9'd1;
    assign pulse_next = tele_inc >= {1'b0, tele_div_reg};
    assign tele_next  = pulse_next ? 8'd0 : tele_inc[7:0];

    // shared multiplier and divide by 100
    assign factor    = cmd.tick ? right_comp_reg : {1'b0, turn_pct_reg};
    assign prod_next = {8'd0, mag_reg} * {10'd0, factor};
    assign est_full  = {13'd0, prod_reg} * {18'd0, dcmw_pkg::RECIP_100};
    assign q_times   = {6'd0, q_reg} * 18'd100;
    assign rem       = prod_reg - q_times;
    assign q_fix     = q_reg + {11'd0, (rem >= 18'd100)};

    assign turn_mag = (q_fix > {2'b00, dcmw_pkg::CMD_MAX}) ? dcmw_pkg::CMD_MAX : q_fix[9:0];
    assign cmag     = (q_fix > {1'b0, dcmw_pkg::RIGHT_MAX}) ? dcmw_pkg::RIGHT_MAX : q_fix[10:0];
    assign cmag_ext = {1'b0, cmag};

    assign pwm_pos  = {1'b0, mag_reg};
    assign turn_pos = {1'b0, turn_mag};

    always_comb
    begin
        unique case (dir_reg)
            DIR_FWD:
            begin
                left_next  = pwm_pos;
                right_next = pwm_pos;
            end
            DIR_BACK:
            begin
                left_next  = -pwm_pos;
                right_next = -pwm_pos;
            end
            DIR_LEFT:
            begin
                left_next  = -turn_pos;
                right_next = turn_pos;
            end
            DIR_RIGHT:
            begin
                left_next  = turn_pos;
                right_next = -turn_pos;
            end
            default:
            begin
                left_next  = 11'sd0;
                right_next = 11'sd0;
            end
        endcase
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_comp_reg <= dcmw_pkg::RIGHT_COMP_RST;
            timeout_reg    <= dcmw_pkg::TIMEOUT_RST;
            min_duty_reg   <= dcmw_pkg::MIN_DUTY_RST;
            turn_pct_reg   <= dcmw_pkg::TURN_PCT_RST;
            tele_div_reg   <= dcmw_pkg::TELE_DIV_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dcmw_pkg::CFG_RIGHT_COMP: right_comp_reg <= cfg_data[7:0];
                dcmw_pkg::CFG_TIMEOUT:    timeout_reg    <= cfg_data[7:0];
                dcmw_pkg::CFG_MIN_DUTY:   min_duty_reg   <= cfg_data;
                dcmw_pkg::CFG_TURN_PCT:   turn_pct_reg   <= cfg_data[6:0];
                dcmw_pkg::CFG_TELE_DIV:   tele_div_reg   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_cmd_reg  <= 11'sd0;
            right_cmd_reg <= 11'sd0;
            idle_reg      <= 9'd0;
            tele_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept && cmd.tick)
            begin
                idle_reg <= idle_next;
                tele_reg <= tele_next;
                if (timeout)
                begin
                    left_cmd_reg  <= 11'sd0;
                    right_cmd_reg <= 11'sd0;
                end
            end
            if (cmd.fix && !cmd.tick)
            begin
                left_cmd_reg  <= left_next;
                right_cmd_reg <= right_next;
                idle_reg      <= 9'd0;
            end
            if (cmd.fix && cmd.tick)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            dir_reg <= dir_next;
            if (cmd.tick)
            begin
                mag_reg   <= timeout ? 10'd0 : abs_right[9:0];
                rneg_reg  <= !timeout && right_cmd_reg[10];
                pulse_reg <= pulse_next;
            end
            else
            begin
                mag_reg <= pwm;
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.est)
        begin
            q_reg <= est_full[dcmw_pkg::RECIP_SHIFT +: 12];
        end
        if (cmd.fix && cmd.tick)
        begin
            left_out_reg  <= left_cmd_reg;
            right_out_reg <= rneg_reg ? -cmag_ext : cmag_ext;
            pulse_out_reg <= pulse_reg;
        end
    end

    assign stat.out_free   = out_free;
    assign out_valid       = out_valid_reg;
    assign left_drive      = left_out_reg;
    assign right_drive     = right_out_reg;
    assign telemetry_pulse = pulse_out_reg;

endmodule

>>> hw/rtl/drive_command_mixer_watchdog.sv
// channel   direction  handshake            payload
// in        request    in_valid / in_stall  func, direction, speed
// out       result     out_valid/out_stall  left_drive, right_drive, telemetry_pulse
// cfg       write      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Every request passes four steps: accept, multiply, reciprocal estimate, correct.
// One shared 10x8 multiplier and a divide-by-100 by reciprocal do the arithmetic.
// A tick holds in its last cycle while a previous result still waits on out_stall.
// Commands give no result. The output register lets a new request be accepted
// while a result is stalled. Reset zeroes commands and counters and loads the
// register defaults.
module drive_command_mixer_watchdog
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                func,
    input  logic [7:0]                          direction,
    input  logic signed [7:0]                   speed,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [10:0]                  left_drive,
    output logic signed [11:0]                  right_drive,
    output logic                                telemetry_pulse,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dcmw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dcmw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    dcmw_pkg::dcmw_cmd_t  cmd;
    dcmw_pkg::dcmw_stat_t stat;

    assign cfg_ready = 1'b1;

    dcmw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    dcmw_dp u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_valid & cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .direction       (direction),
        .speed           (speed),
        .cmd             (cmd),
        .stat            (stat),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .left_drive      (left_drive),
        .right_drive     (right_drive),
        .telemetry_pulse (telemetry_pulse)
    );

endmodule

>>> hw/rtl/dcmw_checker.sv
module dcmw_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             func,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic signed [10:0]               left_drive,
    input logic signed [11:0]               right_drive,
    input logic                             telemetry_pulse
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(left_drive)
            && $stable(right_drive) && $stable(telemetry_pulse))
        else $error("stalled result changed");

    // one request at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while busy");

    // a fresh result comes from an accepted tick
    a_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && func, 4))
        else $error("result without a tick");

    // compensated right duty saturates symmetrically
    a_right_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (right_drive != -12'sd2048) && (left_drive != -11'sd1024))
        else $error("drive out of range");

endmodule

bind drive_command_mixer_watchdog dcmw_checker u_dcmw_checker (.*);
